// ===== src/lpld_pkg.sv =====
`timescale 1ns / 1ps
// lpld_pkg: shared types and codes of the length-prefixed list decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lpld_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END_STR = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NO_DIGITS  = 2'd1;
  localparam logic [1:0] ERR_COUNT_BIG  = 2'd2;
  localparam logic [1:0] ERR_LENGTH_BIG = 2'd3;

  // Depth of the token queue between front and back
  localparam int Q_DEPTH = 2;

  // One classified input byte
  typedef struct packed {
    logic       start;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] data;
  } token_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [7:0]  number;
    logic [15:0] length;
    logic        final_str;
    logic [1:0]  err;
  } result_t;

endpackage

// ===== src/lpld_ram.sv =====
`timescale 1ns / 1ps
// lpld_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/lpld_front.sv =====
`timescale 1ns / 1ps
// lpld_front: input register stage that takes message bytes and classifies them.
// Depends on lpld_pkg (token_t).
module lpld_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_message_start,
  output logic              tok_valid,
  input  logic              tok_ready,
  output lpld_pkg::token_t  tok
);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  logic             valid_r, valid_nxt;
  lpld_pkg::token_t tok_r, tok_nxt;

  assign in_ready = !valid_r || tok_ready;

  always_comb begin
    valid_nxt = valid_r;
    tok_nxt   = tok_r;
    if (valid_r && tok_ready) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt         = 1'b1;
      tok_nxt.start     = in_message_start;
      tok_nxt.is_digit  = (in_data_byte >= CHAR_ZERO) && (in_data_byte <= CHAR_NINE);
      // ASCII digits carry their value in the low nibble
      tok_nxt.digit     = in_data_byte[3:0];
      tok_nxt.data      = in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    tok_r <= tok_nxt;
  end

  assign tok_valid = valid_r;
  assign tok       = tok_r;

endmodule

// ===== src/lpld_queue.sv =====
`timescale 1ns / 1ps
// lpld_queue: short token FIFO that decouples the front from the back.
// Depends on lpld_pkg (token_t, Q_DEPTH).
module lpld_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  lpld_pkg::token_t  push_tok,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lpld_pkg::token_t  pop_tok
);

  localparam int PW = (lpld_pkg::Q_DEPTH > 1) ? $clog2(lpld_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(lpld_pkg::Q_DEPTH + 1);

  lpld_pkg::token_t mem_r [lpld_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CW'(lpld_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(lpld_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(lpld_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== src/lpld_back.sv =====
`timescale 1ns / 1ps
// lpld_back: parse sequencer with the length table and the output register.
// Depends on lpld_pkg (token_t, result_t, codes) and lpld_ram.
module lpld_back #(
  parameter int MAX_STRINGS = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  lpld_pkg::token_t   tok,
  output logic               res_valid,
  input  logic               res_ready,
  output lpld_pkg::result_t  res
);

  localparam int AW     = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int CNT_W  = $clog2(MAX_STRINGS + 1);
  localparam int CACC_W = $clog2(MAX_STRINGS + 2);
  localparam int ACC_W  = (CACC_W > LENGTH_BITS + 1) ? CACC_W : LENGTH_BITS + 1;
  localparam int PW     = ACC_W + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [ACC_W-1:0] LEN_CAP  = ACC_W'(1) << LENGTH_BITS;
  localparam logic [ACC_W-1:0] CNT_CAP  = ACC_W'(MAX_STRINGS + 1);
  localparam logic [ACC_W-1:0] CNT_LIM  = ACC_W'(MAX_STRINGS);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_COUNT   = 4'b0010,
    PH_LENGTHS = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  phase_t                 phase_r, phase_nxt, ph_e;
  logic [ACC_W-1:0]       acc_r, acc_nxt, acc_e, acc_sat, cap;
  logic [PW-1:0]          prod;
  logic                   ds_r, ds_nxt, ds_e;
  logic [CNT_W-1:0]       total_r, total_nxt, total_e;
  logic [CNT_W-1:0]       entry_r, entry_nxt, entry_e, entry_inc, entry_nxt_inc;
  logic [LENGTH_BITS-1:0] brem_r, brem_nxt, brem_e;
  logic [LENGTH_BITS-1:0] cur_len_r, cur_len_nxt;
  logic [LENGTH_BITS-1:0] len0_r, len0_nxt;
  logic [LENGTH_BITS-1:0] len_val, next_len;
  logic                   over, is_last;
  logic                   byp_r, byp_nxt;
  logic [LENGTH_BITS-1:0] byp_data_r;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [LENGTH_BITS-1:0] wr_data, rd_data;
  logic                   adv, emit;
  lpld_pkg::result_t      r;
  logic                   out_valid_r, out_valid_nxt;
  lpld_pkg::result_t      out_res_r;

  lpld_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (MAX_STRINGS)
  ) u_len_tab (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign adv       = tok_valid && (!out_valid_r || res_ready);
  assign tok_ready = !out_valid_r || res_ready;
  assign next_len  = byp_r ? byp_data_r : rd_data;

  always_comb begin
    // restart applies before the byte is parsed
    ph_e    = phase_r;
    acc_e   = acc_r;
    ds_e    = ds_r;
    total_e = total_r;
    entry_e = entry_r;
    brem_e  = brem_r;
    if (tok.start) begin
      ph_e    = PH_COUNT;
      acc_e   = '0;
      ds_e    = 1'b0;
      total_e = '0;
      entry_e = '0;
      brem_e  = '0;
    end

    prod    = PW'({acc_e, 3'b000}) + PW'({acc_e, 1'b0}) + PW'(tok.digit);
    cap     = (ph_e == PH_COUNT) ? CNT_CAP : LEN_CAP;
    acc_sat = (prod > PW'(cap)) ? cap : prod[ACC_W-1:0];

    entry_inc = CNT_W'(entry_e + 1'b1);
    is_last   = (entry_inc == total_e);
    over      = 1'b0;
    len_val   = acc_e[LENGTH_BITS-1:0];

    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    ds_nxt      = ds_r;
    total_nxt   = total_r;
    entry_nxt   = entry_r;
    brem_nxt    = brem_r;
    cur_len_nxt = cur_len_r;
    len0_nxt    = len0_r;
    wr_en       = 1'b0;
    wr_data     = len_val;
    emit        = 1'b0;
    r           = '0;

    if (adv) begin
      phase_nxt = ph_e;
      acc_nxt   = acc_e;
      ds_nxt    = ds_e;
      total_nxt = total_e;
      entry_nxt = entry_e;
      brem_nxt  = brem_e;
      unique case (ph_e)
        PH_IDLE: begin
          // drop bytes outside a message
        end
        PH_COUNT: begin
          if (tok.is_digit) begin
            acc_nxt = acc_sat;
            ds_nxt  = 1'b1;
          end else if (!ds_e) begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            r.kind    = lpld_pkg::KIND_ERROR;
            r.err     = lpld_pkg::ERR_NO_DIGITS;
          end else begin
            over      = (acc_e > CNT_LIM);
            total_nxt = over ? CNT_W'(MAX_STRINGS) : acc_e[CNT_W-1:0];
            acc_nxt   = '0;
            ds_nxt    = 1'b0;
            entry_nxt = '0;
            if (total_nxt == '0) begin
              phase_nxt = PH_IDLE;
              emit      = 1'b1;
              r.kind    = lpld_pkg::KIND_EMPTY;
            end else begin
              phase_nxt = PH_LENGTHS;
              if (over) begin
                emit   = 1'b1;
                r.kind = lpld_pkg::KIND_ERROR;
                r.err  = lpld_pkg::ERR_COUNT_BIG;
              end
            end
          end
        end
        PH_LENGTHS: begin
          if (tok.is_digit) begin
            acc_nxt = acc_sat;
            ds_nxt  = 1'b1;
          end else if (!ds_e) begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            r.kind    = lpld_pkg::KIND_ERROR;
            r.err     = lpld_pkg::ERR_NO_DIGITS;
          end else begin
            over    = (acc_e > ACC_W'(LEN_MAX));
            len_val = over ? LEN_MAX : acc_e[LENGTH_BITS-1:0];
            wr_en   = 1'b1;
            wr_data = len_val;
            acc_nxt = '0;
            ds_nxt  = 1'b0;
            if (entry_e == '0) begin
              len0_nxt = len_val;
            end
            if (is_last) begin
              entry_nxt   = '0;
              brem_nxt    = (entry_e == '0) ? len_val : len0_r;
              cur_len_nxt = brem_nxt;
              phase_nxt   = PH_PAYLOAD;
            end else begin
              entry_nxt = entry_inc;
            end
            if (over) begin
              emit        = 1'b1;
              r.kind      = lpld_pkg::KIND_ERROR;
              r.err       = lpld_pkg::ERR_LENGTH_BIG;
              r.number    = 8'(entry_e);
              r.length    = 16'(len_val);
              r.final_str = is_last;
            end
          end
        end
        PH_PAYLOAD: begin
          emit        = 1'b1;
          r.number    = 8'(entry_e);
          r.length    = 16'(cur_len_r);
          r.final_str = is_last;
          if (brem_e != '0) begin
            brem_nxt  = brem_e - 1'b1;
            r.kind    = lpld_pkg::KIND_PAYLOAD;
            r.payload = tok.data;
          end else begin
            r.kind = lpld_pkg::KIND_END_STR;
            if (is_last) begin
              phase_nxt = PH_IDLE;
              entry_nxt = '0;
            end else begin
              entry_nxt   = entry_inc;
              cur_len_nxt = next_len;
              brem_nxt    = next_len;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // prefetch the length of the string after the next one
    entry_nxt_inc = CNT_W'(entry_nxt + 1'b1);
    rd_addr       = entry_nxt_inc[AW-1:0];
    wr_addr       = entry_e[AW-1:0];
    byp_nxt       = wr_en && (wr_addr == rd_addr);

    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      ds_r        <= 1'b0;
      total_r     <= '0;
      entry_r     <= '0;
      brem_r      <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      ds_r        <= ds_nxt;
      total_r     <= total_nxt;
      entry_r     <= entry_nxt;
      brem_r      <= brem_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_len_r  <= cur_len_nxt;
    len0_r     <= len0_nxt;
    byp_data_r <= wr_data;
    if (emit) begin
      out_res_r <= r;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

endmodule

// ===== src/length_prefixed_list_decoder.sv =====
`timescale 1ns / 1ps
// length_prefixed_list_decoder: one message byte per beat in, at most one result beat out.
// An accepted byte passes the front register and a queue slot before its result beat is registered (out reg).
// Throughput: one byte per cycle sustained; only a stalled result port holds the input back.
// The length table is read one string ahead, so zero-length strings also run at full rate.
// Reset (rst_n low, synchronous) idles the parser and empties queue and output register;
// the length table is not cleared, every entry is written before a message reads it.
module length_prefixed_list_decoder #(
  parameter int MAX_STRINGS = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_string_number,
  output logic [15:0] out_string_length,
  output logic        out_final_string,
  output logic [1:0]  out_error_code
);

  // Front: register and classify each byte (digit, digit value, restart flag)
  logic              f_valid, f_ready;
  lpld_pkg::token_t  f_tok;
  // Queue to back: lets the front keep taking beats while the back waits
  logic              b_valid, b_ready;
  lpld_pkg::token_t  b_tok;
  lpld_pkg::result_t res;

  lpld_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_message_start (in_message_start),
    .tok_valid        (f_valid),
    .tok_ready        (f_ready),
    .tok              (f_tok)
  );

  lpld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_tok    (b_tok)
  );

  // Back: parse count and lengths, fill the length table, tag payload beats.
  // It owns the output register, so it advances whenever that register frees up.
  lpld_back #(
    .MAX_STRINGS (MAX_STRINGS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (b_valid),
    .tok_ready (b_ready),
    .tok       (b_tok),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_item_kind     = res.kind;
  assign out_payload_byte  = res.payload;
  assign out_string_number = res.number;
  assign out_string_length = res.length;
  assign out_final_string  = res.final_str;
  assign out_error_code    = res.err;

`ifndef SYNTH
  // An error code rides only on error beats, and every error beat has one
  a_err_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item_kind == lpld_pkg::KIND_ERROR) ==
                   (out_error_code != lpld_pkg::ERR_NONE)))
    else $error("error code and item kind disagree");

  // Only payload beats carry a data byte
  a_payload_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item_kind != lpld_pkg::KIND_PAYLOAD)) |-> (out_payload_byte == 8'd0))
    else $error("payload byte set on a non-payload beat");

  // Empty-list beats carry no string tag
  a_empty_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item_kind == lpld_pkg::KIND_EMPTY)) |->
      ((out_string_number == 8'd0) && (out_string_length == 16'd0) && !out_final_string))
    else $error("empty-list beat carries string fields");
`endif

endmodule

// ===== sim/lpld_checker.sv =====
`timescale 1ns / 1ps
// lpld_checker: predicts the result beats of length_prefixed_list_decoder from the input
// beats it observes and compares them with the result channel. Depends on lpld_pkg.
module lpld_checker #(
  parameter int MAX_STRINGS = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_item_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic [7:0]  out_string_number,
  input  logic [15:0] out_string_length,
  input  logic        out_final_string,
  input  logic [1:0]  out_error_code,
  output int          fail_count,
  output int          pending_count
);

  localparam longint LEN_LIMIT = (64'd1 << LENGTH_BITS) - 1;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {PH_IDLE, PH_COUNT, PH_LENGTHS, PH_PAYLOAD} phase_t;

  phase_t                 phase;
  longint                 number;
  logic                   digit_seen;
  int                     string_total;
  int                     entry;
  longint                 bytes_left;
  logic [LENGTH_BITS-1:0] length_table [MAX_STRINGS];
  lpld_pkg::result_t      expected_results [$];
  lpld_pkg::result_t      oldest;

  function automatic lpld_pkg::result_t build_result(input logic [1:0] kind,
                                                     input logic [7:0] payload,
                                                     input int idx, input longint len,
                                                     input logic fin,
                                                     input logic [1:0] err);
    lpld_pkg::result_t r;
    r.kind      = kind;
    r.payload   = payload;
    r.number    = idx[7:0];
    r.length    = len[15:0];
    r.final_str = fin;
    r.err       = err;
    return r;
  endfunction

  // Append one beat at the tail of the expected list.
  task automatic expect_beat(input lpld_pkg::result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic accumulate(input int d, input longint cap);
    number = number * 10 + d;
    if (number > cap) number = cap;
    digit_seen = 1'b1;
  endtask

  // Advance the parse by one byte and queue the result beat it causes, if any.
  task automatic decode_byte(input logic [7:0] b, input logic restart);
    logic   is_digit;
    logic   over;
    longint len;
    int     idx;
    logic   fin;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    if (restart) begin
      phase        = PH_COUNT;
      number       = 0;
      digit_seen   = 1'b0;
      string_total = 0;
      entry        = 0;
      bytes_left   = 0;
    end
    case (phase)
      PH_COUNT: begin
        if (is_digit) begin
          accumulate(int'(b) - int'(CH_ZERO), longint'(MAX_STRINGS + 1));
        end else if (!digit_seen) begin
          phase = PH_IDLE;
          expect_beat(build_result(lpld_pkg::KIND_ERROR, '0, '0, '0, '0,
                                   lpld_pkg::ERR_NO_DIGITS));
        end else begin
          over         = number > MAX_STRINGS;
          string_total = over ? MAX_STRINGS : int'(number);
          number       = 0;
          digit_seen   = 1'b0;
          entry        = 0;
          if (string_total == 0) begin
            phase = PH_IDLE;
            expect_beat(build_result(lpld_pkg::KIND_EMPTY, '0, '0, '0, '0,
                                     lpld_pkg::ERR_NONE));
          end else begin
            phase = PH_LENGTHS;
            if (over)
              expect_beat(build_result(lpld_pkg::KIND_ERROR, '0, '0, '0, '0,
                                       lpld_pkg::ERR_COUNT_BIG));
          end
        end
      end
      PH_LENGTHS: begin
        if (is_digit) begin
          accumulate(int'(b) - int'(CH_ZERO), LEN_LIMIT + 1);
        end else if (!digit_seen || entry >= string_total) begin
          phase = PH_IDLE;
          expect_beat(build_result(lpld_pkg::KIND_ERROR, '0, '0, '0, '0,
                                   lpld_pkg::ERR_NO_DIGITS));
        end else begin
          over              = number > LEN_LIMIT;
          len               = over ? LEN_LIMIT : number;
          idx               = entry;
          length_table[idx] = len[LENGTH_BITS-1:0];
          number            = 0;
          digit_seen        = 1'b0;
          entry             = idx + 1;
          if (entry >= string_total) begin
            entry      = 0;
            bytes_left = longint'(length_table[0]);
            phase      = PH_PAYLOAD;
          end
          if (over)
            expect_beat(build_result(lpld_pkg::KIND_ERROR, '0, idx, len,
                                     idx + 1 == string_total, lpld_pkg::ERR_LENGTH_BIG));
        end
      end
      PH_PAYLOAD: begin
        if (entry >= string_total) begin
          phase = PH_IDLE;
        end else begin
          idx = entry;
          len = longint'(length_table[idx]);
          fin = (idx + 1 == string_total);
          if (bytes_left > 0) begin
            bytes_left--;
            expect_beat(build_result(lpld_pkg::KIND_PAYLOAD, b, idx, len, fin,
                                     lpld_pkg::ERR_NONE));
          end else begin
            // The byte after the last payload byte is the separator.
            expect_beat(build_result(lpld_pkg::KIND_END_STR, '0, idx, len, fin,
                                     lpld_pkg::ERR_NONE));
            entry = idx + 1;
            if (entry >= string_total) begin
              phase = PH_IDLE;
              entry = 0;
            end else begin
              bytes_left = longint'(length_table[entry]);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase        = PH_IDLE;
      number       = 0;
      digit_seen   = 1'b0;
      string_total = 0;
      entry        = 0;
      bytes_left   = 0;
      fail_count   = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(in_data_byte, in_message_start);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, actual kind %0d",
                   $time, out_item_kind, " payload %0d string %0d length %0d final %0d",
                   out_payload_byte, out_string_number, out_string_length, out_final_string,
                   " error %0d", out_error_code);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("item_kind", int'(oldest.kind), int'(out_item_kind));
          check_field("payload_byte", int'(oldest.payload), int'(out_payload_byte));
          check_field("string_number", int'(oldest.number), int'(out_string_number));
          check_field("string_length", int'(oldest.length), int'(out_string_length));
          check_field("final_string", int'(oldest.final_str), int'(out_final_string));
          check_field("error_code", int'(oldest.err), int'(out_error_code));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: feeds encoded list messages to length_prefixed_list_decoder and gives the verdict.
// Depends on lpld_pkg, the decoder RTL and lpld_checker (sim/lpld_checker.sv).
module testbench;

  localparam int MAX_STRINGS  = 256;
  localparam int LENGTH_BITS  = 16;
  // Bytes to send over the whole run, directed part included.
  localparam int TOTAL_BYTES  = 500;
  // Cycles without any beat before the run is called hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles to watch for stray result beats once nothing is expected.
  localparam int DRAIN_CYCLES = 12;
  localparam int NO_LIMIT     = 32'h3FFF_FFFF;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_message_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_item_kind;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_string_number;
  logic [15:0] out_string_length;
  logic        out_final_string;
  logic [1:0]  out_error_code;

  int   fail_count;
  int   pending_count;
  int   idle_cycles = 0;
  int   sent_bytes  = 0;
  int   byte_budget = NO_LIMIT;
  logic start_pending = 1'b0;
  // Set for the last part of the run: no gaps, no stalls.
  bit   quiet = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  length_prefixed_list_decoder #(
    .MAX_STRINGS(MAX_STRINGS),
    .LENGTH_BITS(LENGTH_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_message_start (in_message_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_payload_byte (out_payload_byte),
    .out_string_number(out_string_number),
    .out_string_length(out_string_length),
    .out_final_string (out_final_string),
    .out_error_code   (out_error_code)
  );

  lpld_checker #(
    .MAX_STRINGS(MAX_STRINGS),
    .LENGTH_BITS(LENGTH_BITS)
  ) result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_message_start (in_message_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_payload_byte (out_payload_byte),
    .out_string_number(out_string_number),
    .out_string_length(out_string_length),
    .out_final_string (out_final_string),
    .out_error_code   (out_error_code),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("length_prefixed_list_decoder test failed");
          $finish;
        end
      end
    end
  end

  // Result side: hold ready low in random bursts, none in the quiet part.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Drive one beat from a falling edge and hold it until a rising edge accepts it.
  // Returns at the falling edge after acceptance, with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_message_start <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send one byte of a message; drop it once the message's byte budget runs out,
  // which is how truncated messages are made.
  task automatic put(input logic [7:0] b);
    if (byte_budget == 0) return;
    byte_budget--;
    send_byte(b, start_pending);
    start_pending = 1'b0;
    sent_bytes++;
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b >= CH_ZERO && b <= CH_NINE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Decimal digits, now and then with leading zeros.
  task automatic put_number(input int v);
    string digits;
    int    zeros;
    digits = $sformatf("%0d", v);
    zeros  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) put(CH_ZERO);
    for (int i = 0; i < digits.len(); i++) put(digits[i]);
  endtask

  // One encoded list: count, lengths, then payload plus separator per string.
  // skip_at leaves out the digits of that length (the parse then goes idle);
  // big_at makes that length oversized and stops after the lengths.
  task automatic send_list(input int n, input int max_len, input int skip_at, input int big_at);
    int lens [MAX_STRINGS];
    int eff;
    eff = (n > MAX_STRINGS) ? MAX_STRINGS : n;
    start_pending = 1'b1;
    put_number(n);
    put(non_digit());
    for (int i = 0; i < eff; i++) begin
      if (i == skip_at) begin
        put(non_digit());
        return;
      end
      if (i == big_at) lens[i] = int'($urandom_range(32'd65536, 32'd2000000000));
      else lens[i] = int'($urandom_range(0, max_len));
      put_number(lens[i]);
      put(non_digit());
    end
    if (big_at >= 0) return;
    for (int i = 0; i < eff; i++) begin
      repeat (lens[i]) put(8'($urandom_range(0, 255)));
      // The separator may be any byte, digits included.
      put(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int  pick;
    int  n;
    bit  drained;
    drained          = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = 8'h00;
    in_message_start = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    // A byte with no parse running is ignored.
    put(8'hFF);
    // Count terminator with no digits before it.
    start_pending = 1'b1;
    put(":");
    // Zero count: empty list.
    start_pending = 1'b1;
    put("0");
    put(8'h00);
    // Count over the bound, then dropped by the next message start.
    start_pending = 1'b1;
    put("2");
    put("5");
    put("7");
    put(",");
    // Length over the bound, then dropped by a restart.
    start_pending = 1'b1;
    put("1");
    put(":");
    put("9");
    put("9");
    put("9");
    put("9");
    put("9");
    put(" ");
    // Length terminator with no digits.
    start_pending = 1'b1;
    put("1");
    put(":");
    put(":");
    // Two strings, the second empty; length terminators just either side of the digit range.
    start_pending = 1'b1;
    put("2");
    put(";");
    put("2");
    put(8'h2F);
    put("0");
    put(8'h3A);
    put(8'h00);
    put(8'hFF);
    put("7");
    put("5");
    // End of list reached: this one is ignored.
    put(8'h41);

    // Random part: mostly well-formed lists, mixed with truncated and broken ones and noise.
    while (sent_bytes < TOTAL_BYTES) begin
      if (!drained && sent_bytes >= TOTAL_BYTES / 2) begin
        // Hold off the sender until every expected result beat is out.
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        drained = 1'b1;
      end
      if (sent_bytes >= TOTAL_BYTES * 4 / 5) quiet = 1'b1;
      n           = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      byte_budget = NO_LIMIT;
      pick        = $urandom_range(0, 99);
      if (pick < 60) begin
        send_list(n, ($urandom_range(0, 5) == 0) ? 40 : 6, -1, -1);
      end else if (pick < 70) begin
        byte_budget = $urandom_range(1, 15);
        send_list(n, 6, -1, -1);
      end else if (pick < 77) begin
        send_list(n + 1, 6, $urandom_range(0, n), -1);
      end else if (pick < 83) begin
        byte_budget = $urandom_range(4, 30);
        send_list($urandom_range(MAX_STRINGS + 1, 99999), 4, -1, -1);
      end else if (pick < 89) begin
        send_list(n + 1, 6, -1, $urandom_range(0, n));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          start_pending = ($urandom_range(0, 7) == 0);
          put(8'($urandom_range(0, 255)));
        end
      end
    end

    // Drain: wait for every expected beat, then watch a little longer for strays.
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("length_prefixed_list_decoder test passed");
    end else begin
      $display("length_prefixed_list_decoder test failed");
    end
    $finish;
  end

endmodule
